// File: rtl/daily_minutes_log_table_assert.svh
// -----------------------------------------------------------------------------
// Daily minutes log table assertion macros
// Shared macros for the concurrent checks of the log table design.
// -----------------------------------------------------------------------------
`ifndef DAILY_MINUTES_LOG_TABLE_ASSERT_SVH
`define DAILY_MINUTES_LOG_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMLT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("log table check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("log table check failed");

`endif

// File: rtl/dmlt_pkg.sv
// -----------------------------------------------------------------------------
// Daily minutes log table package
// Shared constants, command codes, controller states and calendar helper.
// -----------------------------------------------------------------------------
package dmlt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned EntryW        = 48;
  localparam int unsigned SessW         = 32;
  localparam logic [15:0] MinYearRst    = 16'd2020;
  localparam logic [15:0] MinutesMax    = 16'hFFFF;
  localparam logic [21:0] Out22Max      = 22'h3FFFFF;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_OPEN   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SRCH,
    ST_SRCH_CHK,
    ST_INS,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  // Length of a month, zero for an invalid month. A year is divisible by 25
  // when it equals its reciprocal-estimated quotient times 25.
  function automatic logic [4:0] days_in_month(logic [15:0] y, logic [7:0] m);
    logic [32:0] prod;
    logic [11:0] q;
    logic [15:0] q25;
    logic        leap;
    logic [4:0]  len;
    prod = {17'd0, y} * 33'd83887;
    q    = prod[32:21];
    q25  = {q, 4'd0} + {1'b0, q, 3'd0} + {4'd0, q};
    leap = (y[1:0] == 2'd0) && ((y != q25) || (y[3:0] == 4'd0));
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 5'd30;
      8'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/dmlt_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module dmlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dmlt_div.sv
// -----------------------------------------------------------------------------
// Daily minutes log table divider
// Restoring divider producing one quotient bit per cycle.
// -----------------------------------------------------------------------------
module dmlt_div #(
  parameter int unsigned NumW = 33,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW:0]   rem_q, rem_d, rem_sh;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/daily_minutes_log_table.sv
// -----------------------------------------------------------------------------
// Daily minutes log table
// Keeps a date-sorted table of daily reading minutes and a session counter.
// -----------------------------------------------------------------------------
// The input stream carries one command per transaction: the command code in
// s_axis_tuser_i and the date and minutes in s_axis_tdata_i. Every accepted
// transaction yields exactly one result transaction on the master side with
// the total minutes, the rounded average per session, the days read in the
// given month and the ignored and evicted flags.
// Items are processed one at a time. A query reads every stored entry to sum
// its minutes, then runs the divider for the average; while no session has
// been opened the divider is skipped. A record first searches the table from
// the newest entry down and, when a new date is inserted, shifts entries to
// make room for it. The table RAM has a registered read and the divider gives
// one quotient bit per cycle. The minimum year is written through cfg_we_i;
// the user must do so only while the block is idle, which the block itself
// does not enforce.
// After reset the table and the session counter are empty and the minimum
// year is 2020; no clearing pass is needed. A finished result waits in the
// output register while the receiver stalls, and the next item is already
// accepted and processed meanwhile; it finishes only once that slot is free.
// -----------------------------------------------------------------------------
module daily_minutes_log_table
  import dmlt_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // year [15:0], month [23:16], day [31:24], minutes [47:32]
  input  logic [47:0] s_axis_tdata_i,
  // command [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // total_minutes [21:0], average_minutes [43:22], days_read [48:44],
  // ignored [49], evicted [50], zero [55:51]
  output logic [55:0] m_axis_tdata_o
);

  localparam int unsigned AW   = $clog2(TableDepth);
  localparam int unsigned SumW = 16 + $clog2(TableDepth + 1);
  localparam int unsigned TotW = (SumW > 22) ? SumW : 22;
  localparam int unsigned NumW = ((SumW > SessW) ? SumW : SessW) + 1;

  state_e            state_q, state_d;
  logic [15:0]       min_year_q;
  logic [SessW-1:0]  sess_q, sess_d;
  logic [AW:0]       count_q, count_d;
  logic [AW:0]       idx_q, idx_d;
  logic [AW:0]       pos_q, pos_d;
  cmd_e              cmd_q;
  logic [15:0]       year_q;
  logic [7:0]        month_q;
  logic [7:0]        day_q;
  logic [15:0]       mins_q;
  logic [4:0]        dim_q, dim_d;
  logic [SumW-1:0]   total_q, total_d;
  logic [4:0]        days_q, days_d;
  logic              ign_q, ign_d;
  logic              evc_q, evc_d;
  logic              m_valid_q, m_valid_d;
  logic [55:0]       m_data_q, m_data_d;

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [31:0]       key, rd_key;
  logic [15:0]       rd_min;
  logic [16:0]       add_min;
  logic [AW:0]       idx_dec, idx_inc, pos_dec;
  logic              out_free;
  logic              day_hit;
  logic              div_start, div_done;
  logic [NumW-1:0]   div_num, div_quo;
  logic [TotW-1:0]   total_ext;
  logic [21:0]       total_sat, avg_sat;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign key      = {year_q, month_q, day_q};
  assign rd_key   = ram_rdata[47:16];
  assign rd_min   = ram_rdata[15:0];
  assign add_min  = {1'b0, rd_min} + {1'b0, mins_q};
  assign idx_dec  = idx_q - 1'b1;
  assign idx_inc  = idx_q + 1'b1;
  assign pos_dec  = pos_q - 1'b1;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign day_hit  = (ram_rdata[47:32] == year_q) && (ram_rdata[31:24] == month_q) &&
                    (ram_rdata[23:16] != 8'd0) && (ram_rdata[23:16] <= {3'd0, dim_q}) &&
                    (rd_min != 16'd0);

  assign total_ext = TotW'(total_q);
  assign total_sat = (total_ext > TotW'(Out22Max)) ? Out22Max : total_ext[21:0];
  assign div_num   = NumW'(total_q) + NumW'(sess_q[SessW-1:1]);
  assign avg_sat   = (sess_q == '0) ? 22'd0 :
                     ((div_quo > NumW'(Out22Max)) ? Out22Max : div_quo[21:0]);

  dmlt_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dmlt_div #(
    .NumW (NumW),
    .DenW (SessW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sess_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid_i) state_d = ST_PREP;
      ST_PREP:     state_d = (cmd_q == CMD_RECORD && !ign_q) ? ST_SRCH : ST_SUM_RD;
      ST_SRCH:     state_d = (idx_q == '0) ? ST_INS : ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (rd_key == key) begin
          state_d = ST_SUM_RD;
        end else if (rd_key < key) begin
          state_d = ST_INS;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_INS: begin
        if (count_q < (AW+1)'(TableDepth)) begin
          state_d = ST_UP_RD;
        end else if (pos_q == '0) begin
          state_d = ST_SUM_RD;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_UP_RD:    state_d = (idx_q == pos_q) ? ST_SUM_RD : ST_UP_WR;
      ST_UP_WR:    state_d = ST_UP_RD;
      ST_DN_RD:    state_d = (idx_q == pos_dec) ? ST_SUM_RD : ST_DN_WR;
      ST_DN_WR:    state_d = ST_DN_RD;
      ST_SUM_RD: begin
        if (idx_q == count_q) begin
          state_d = (sess_q == '0) ? ST_OUT : ST_DIV;
        end else begin
          state_d = ST_SUM_ACC;
        end
      end
      ST_SUM_ACC:  state_d = ST_SUM_RD;
      ST_DIV:      state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    sess_d    = sess_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    dim_d     = dim_q;
    total_d   = total_q;
    days_d    = days_q;
    ign_d     = ign_q;
    evc_d     = evc_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_waddr = idx_dec[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_dec[AW-1:0];
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_e'(s_axis_tuser_i) == CMD_OPEN) begin
          sess_d = sess_q + 1'b1;
        end
        ign_d = (cmd_e'(s_axis_tuser_i) == CMD_RECORD) &&
                (s_axis_tdata_i[15:0] < min_year_q);
        evc_d = 1'b0;
      end
      ST_PREP: begin
        dim_d   = days_in_month(year_q, month_q);
        total_d = '0;
        days_d  = '0;
        idx_d   = (cmd_q == CMD_RECORD && !ign_q) ? count_q : '0;
      end
      ST_SRCH: begin
        if (idx_q == '0) begin
          pos_d = '0;
        end
      end
      ST_SRCH_CHK: begin
        if (rd_key == key) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, add_min[16] ? MinutesMax : add_min[15:0]};
          idx_d     = '0;
        end else if (rd_key < key) begin
          pos_d = idx_q;
        end else begin
          idx_d = idx_dec;
        end
      end
      ST_INS: begin
        if (count_q < (AW+1)'(TableDepth)) begin
          idx_d = count_q;
        end else begin
          evc_d = 1'b1;
          idx_d = '0;
        end
      end
      ST_UP_RD: begin
        if (idx_q == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = {key, mins_q};
          count_d   = count_q + 1'b1;
          idx_d     = '0;
        end
      end
      ST_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_dec;
      end
      ST_DN_RD: begin
        ram_raddr = idx_inc[AW-1:0];
        if (idx_q == pos_dec) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = {key, mins_q};
          idx_d     = '0;
        end
      end
      ST_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_inc;
      end
      ST_SUM_RD: begin
        ram_raddr = idx_q[AW-1:0];
      end
      ST_SUM_ACC: begin
        total_d = total_q + SumW'(rd_min);
        days_d  = days_q + 5'(day_hit);
        idx_d   = idx_inc;
      end
      ST_DIV: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
      end
      ST_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, evc_q, ign_q, days_q, avg_sat, total_sat};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      min_year_q <= MinYearRst;
      sess_q     <= '0;
      count_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      sess_q    <= sess_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        min_year_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    dim_q    <= dim_d;
    total_q  <= total_d;
    days_q   <= days_d;
    ign_q    <= ign_d;
    evc_q    <= evc_d;
    m_data_q <= m_data_d;
    if (accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser_i);
      year_q  <= s_axis_tdata_i[15:0];
      month_q <= s_axis_tdata_i[23:16];
      day_q   <= s_axis_tdata_i[31:24];
      mins_q  <= s_axis_tdata_i[47:32];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`include "daily_minutes_log_table_assert.svh"

  `DMLT_ASSERT_SAME(a_count_bound, 1'b1, count_q <= (AW+1)'(TableDepth))
  `DMLT_ASSERT_SAME(a_flags_excl, m_valid_q, !(m_data_q[49] && m_data_q[50]))
  `DMLT_ASSERT_SAME(a_evict_full, m_valid_q && m_data_q[50], count_q == (AW+1)'(TableDepth))
  `DMLT_ASSERT_NEXT(a_div_start, state_q == ST_DIV, state_q == ST_DIV_WAIT && sess_q != '0)

endmodule
